// ===== hw/rtl/rsd_pkg.sv =====
package rsd_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0]  REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [7:0]  REG_IMAGE_HEIGHT = 8'd1;

  localparam logic [15:0] COLOUR_SHADOW = 16'h001F;
  localparam logic [15:0] COLOUR_CLEAR  = 16'h07C0;
  localparam logic [15:0] ROW_SKIP      = 16'hFFFE;
  localparam logic [7:0]  ALPHA_SHADOW  = 8'd127;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'd255;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_TOTAL,
    PH_COLOUR,
    PH_DONE,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [15:0] run_length;
    logic        row_end;
    logic        image_end;
    logic        malformed;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic result_t run_result(input logic [15:0] len);
    result_t r;
    r            = '0;
    r.run_length = len;
    return r;
  endfunction

  function automatic result_t pixel_result(input logic [15:0] c);
    result_t r;
    r            = '0;
    r.run_length = 16'd1;
    if (c == COLOUR_SHADOW) begin
      r.alpha = ALPHA_SHADOW;
    end else if (c == COLOUR_CLEAR) begin
      r.alpha = 8'd0;
    end else begin
      r.red   = {c[15:11], c[15:13]};
      r.green = {c[10:5], c[10:9]};
      r.blue  = {c[4:0], c[4:2]};
      r.alpha = ALPHA_OPAQUE;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rsd_in_if.sv =====
interface rsd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_word;
  logic        start_req;

  modport source (output valid, output data_word, output start_req, input ready);
  modport sink   (input valid, input data_word, input start_req, output ready);
endinterface

// ===== hw/rtl/rsd_out_if.sv =====
interface rsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [7:0]  alpha;
  logic [15:0] run_length;
  logic        row_end;
  logic        image_end;
  logic        malformed;

  modport source (output valid, output blue, output green, output red, output alpha,
                  output run_length, output row_end, output image_end, output malformed,
                  input ready);
  modport sink   (input valid, input blue, input green, input red, input alpha,
                  input run_length, input row_end, input image_end, input malformed,
                  output ready);
endinterface

// ===== hw/rtl/rsd_cfg_if.sv =====
interface rsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hw/rtl/rsd_core.sv =====
module rsd_core (
  input  logic               clk,
  input  logic               rst,
  rsd_in_if.sink             sprite_in,
  input  logic [15:0]        image_width,
  input  logic [15:0]        image_height,
  input  logic               room,
  output rsd_pkg::push_t     push
);

  logic                in_valid_q;
  logic [15:0]         word_q;
  logic                start_q;
  logic                consume;

  rsd_pkg::phase_t     phase, phase_next;
  logic [15:0]         row_index, row_index_next;
  logic [15:0]         lead_count, lead_count_next;
  logic [15:0]         visible_total, visible_total_next;
  logic [15:0]         colours_left, colours_left_next;

  rsd_pkg::phase_t     cur_phase;
  logic [15:0]         cur_row;
  logic signed [17:0]  lead_s, total_s, width_s;
  logic                bad_hdr;
  logic [15:0]         total16, cl_new, left_dec, tail_total, trail;
  logic                do_tail, do_end, row_last;

  assign consume         = in_valid_q && room;
  assign sprite_in.ready = !in_valid_q || consume;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (sprite_in.ready) begin
      in_valid_q <= sprite_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sprite_in.ready && sprite_in.valid) begin
      word_q  <= sprite_in.data_word;
      start_q <= sprite_in.start_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rsd_pkg::PH_LEAD;
      row_index     <= '0;
      lead_count    <= '0;
      visible_total <= '0;
      colours_left  <= '0;
    end else begin
      phase         <= phase_next;
      row_index     <= row_index_next;
      lead_count    <= lead_count_next;
      visible_total <= visible_total_next;
      colours_left  <= colours_left_next;
    end
  end

  assign cur_phase  = start_q ? rsd_pkg::PH_LEAD : phase;
  assign cur_row    = start_q ? 16'd0 : row_index;
  assign lead_s     = {{2{lead_count[15]}}, lead_count};
  assign total_s    = {{2{word_q[15]}}, word_q} + 18'sd1;
  assign width_s    = {2'b00, image_width};
  assign bad_hdr    = lead_count[15] || (lead_s > total_s) || (total_s > width_s);
  assign total16    = total_s[15:0];
  assign cl_new     = total16 - lead_count;
  assign left_dec   = (colours_left != 16'd0) ? colours_left - 16'd1 : 16'd0;
  assign tail_total = (cur_phase == rsd_pkg::PH_TOTAL) ? total16 : visible_total;
  assign trail      = (image_width > tail_total) ? image_width - tail_total : 16'd0;
  assign row_last   = ({1'b0, cur_row} + 17'd1) >= {1'b0, image_height};

  always_comb begin
    phase_next         = phase;
    row_index_next     = row_index;
    lead_count_next    = lead_count;
    visible_total_next = visible_total;
    colours_left_next  = colours_left;
    push               = '0;
    do_tail            = 1'b0;
    do_end             = 1'b0;

    if (consume) begin
      if (start_q) begin
        row_index_next    = '0;
        colours_left_next = '0;
        phase_next        = rsd_pkg::PH_LEAD;
      end
      case (cur_phase)
        rsd_pkg::PH_LEAD: begin
          lead_count_next = word_q;
          phase_next      = rsd_pkg::PH_TOTAL;
        end
        rsd_pkg::PH_TOTAL: begin
          if (word_q == rsd_pkg::ROW_SKIP) begin
            push.res0 = rsd_pkg::run_result(image_width);
            push.n    = 2'd1;
            do_end    = 1'b1;
          end else if (bad_hdr) begin
            push.res0           = '0;
            push.res0.malformed = 1'b1;
            push.n              = 2'd1;
            phase_next          = rsd_pkg::PH_HALT;
          end else begin
            visible_total_next = total16;
            if (lead_count != 16'd0) begin
              push.res0 = rsd_pkg::run_result(lead_count);
              push.n    = 2'd1;
            end
            colours_left_next = cl_new;
            if (cl_new == 16'd0) begin
              do_tail = 1'b1;
            end else begin
              phase_next = rsd_pkg::PH_COLOUR;
            end
          end
        end
        rsd_pkg::PH_COLOUR: begin
          push.res0         = rsd_pkg::pixel_result(word_q);
          push.n            = 2'd1;
          colours_left_next = left_dec;
          if (left_dec == 16'd0) begin
            do_tail = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (do_tail) begin
        if (trail != 16'd0 || push.n == 2'd0) begin
          if (push.n == 2'd0) begin
            push.res0 = rsd_pkg::run_result(trail);
          end else begin
            push.res1 = rsd_pkg::run_result(trail);
          end
          push.n = push.n + 2'd1;
        end
        do_end = 1'b1;
      end

      if (do_end) begin
        if (push.n == 2'd2) begin
          push.res1.row_end   = 1'b1;
          push.res1.image_end = row_last;
        end else begin
          push.res0.row_end   = 1'b1;
          push.res0.image_end = row_last;
        end
        if (row_last) begin
          phase_next = rsd_pkg::PH_DONE;
        end else begin
          row_index_next = cur_row + 16'd1;
          phase_next     = rsd_pkg::PH_LEAD;
        end
      end
    end
  end

  // stopped decoder stays silent until a restart
  a_silent_when_stopped: assert property (@(posedge clk) disable iff (rst)
    (consume && !start_q && (phase == rsd_pkg::PH_DONE || phase == rsd_pkg::PH_HALT))
      |-> push.n == 2'd0)
    else $error("result produced after image end or malformed header");

  a_malformed_alone: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0 && push.res0.malformed)
      |-> push.n == 2'd1 ##1 phase == rsd_pkg::PH_HALT)
    else $error("malformed result not single or decoder not halted");

  a_image_end_done: assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd1 && push.res0.image_end) || (push.n == 2'd2 && push.res1.image_end)
      |=> phase == rsd_pkg::PH_DONE)
    else $error("image end without entering done phase");

endmodule

// ===== hw/rtl/rsd_result_fifo.sv =====
module rsd_result_fifo (
  input  logic               clk,
  input  logic               rst,
  input  rsd_pkg::push_t     push,
  output logic               room,
  rsd_out_if.source          pixel_out
);

  localparam int DEPTH = rsd_pkg::FIFO_DEPTH;
  localparam int AW    = rsd_pkg::FIFO_AW;

  rsd_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             pop;
  rsd_pkg::result_t head;

  assign room = count <= (AW+1)'(DEPTH - 2);
  assign pop  = pixel_out.valid && pixel_out.ready;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push.n) - (AW+1)'(pop);
    end
  end

  assign pixel_out.valid      = count != '0;
  assign pixel_out.blue       = head.blue;
  assign pixel_out.green      = head.green;
  assign pixel_out.red        = head.red;
  assign pixel_out.alpha      = head.alpha;
  assign pixel_out.run_length = head.run_length;
  assign pixel_out.row_end    = head.row_end;
  assign pixel_out.image_end  = head.image_end;
  assign pixel_out.malformed  = head.malformed;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> ({1'b0, count} + (AW+2)'(push.n)) <= (AW+2)'(DEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("result queue count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push.n == 2'd0) |=> count == $past(count) - (AW+1)'(1))
    else $error("queue count wrong after beat out");

endmodule

// ===== hw/rtl/rle_sprite_rgb565_decoder.sv =====
// Run-length sprite decoder, RGB565 rows to BGRA8888 pixels and runs.
// sprite_in: one 16-bit sprite data word per beat; start_req on a beat
//   restarts decoding at row 0 and that word is row 0's transparent count.
// pixel_out: one result per beat, a single pixel (run_length 1), a
//   transparent run, or a malformed-header marker; row_end/image_end flag
//   the last result of a row/image.
// cfg: register writes, index 0 image_width, index 1 image_height, always
//   ready; write only while the decoder is idle. Other indexes are ignored.
// Path: an accepted word is held in the input register, decoded
//   combinationally and written to the result queue, whose head drives
//   pixel_out.
// Throughput: one word per cycle while the result queue has room; a word
//   producing two results (a row end with a trailing run) takes two beats
//   out. The four entry result queue accepts a decode only with two entries free.
// Reset: width and height return to 1, decoding awaits row 0's header.
// Stalls on pixel_out fill the queue, then back-pressure sprite_in via
//   ready; no result is dropped.
module rle_sprite_rgb565_decoder (
  input  logic      clk,
  input  logic      rst,
  rsd_cfg_if.sink   cfg,
  rsd_in_if.sink    sprite_in,
  rsd_out_if.source pixel_out
);

  logic [15:0]    image_width;
  logic [15:0]    image_height;
  logic           room;
  rsd_pkg::push_t push;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd1;
      image_height <= 16'd1;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        rsd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.wdata;
        rsd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.wdata;
        default: begin
        end
      endcase
    end
  end

  rsd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .sprite_in    (sprite_in),
    .image_width  (image_width),
    .image_height (image_height),
    .room         (room),
    .push         (push)
  );

  rsd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .pixel_out (pixel_out)
  );

endmodule
